FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the log unit RTL.
// Define NO_ASSERTIONS to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define CFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define CFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/cfl_pkg.sv
// ---------------------------------------------------------------------------
// cfl_pkg
// Types and constants of the continued fraction log unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cfl_pkg;

  // Fraction bits of z, z^2 and the level accumulator
  localparam int Z_BITS    = 30;
  // Term count register
  localparam int K_W       = 8;
  localparam logic [K_W-1:0] TERM_RESET = 8'd8;
  // Result width and saturation limit of the magnitude
  localparam int OUT_W     = 21;
  localparam int MAG_W     = OUT_W - 1;
  // Multiplier operand width and product width
  localparam int MUL_W     = 30;
  localparam int PROD_W    = 2 * MUL_W;
  // Level numerator: (k-1)^2 (16 bits) times z^2 (30 bits)
  localparam int KSQ_W     = 2 * K_W;
  localparam int NUM_W     = KSQ_W + Z_BITS;
  // Divider: dividend covers numerator shifted by Z_BITS
  localparam int DVD_W     = NUM_W + Z_BITS;
  // Divisor covers (2k-1) * 2^30 with 2k-1 < 2^9
  localparam int TOP_W     = K_W + 1;
  localparam int DSR_W     = TOP_W + Z_BITS;
  localparam int QUO_W     = DSR_W + 1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZDIV,
    ST_ZWAIT,
    ST_ZSQ,
    ST_ZSQ_WB,
    ST_LEVEL,
    ST_NUM,
    ST_ADIV,
    ST_AWAIT,
    ST_FDIV,
    ST_FWAIT,
    ST_DONE
  } cfl_state_t;

  // Divider request
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  // Divider response
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic             valid;
    logic             invalid;
    logic [OUT_W-1:0] ln;
  } cfl_res_t;

endpackage

`default_nettype wire

FILE: rtl/continued_fraction_log_unit.sv
// ---------------------------------------------------------------------------
// continued_fraction_log_unit
// ln(x) of an unsigned fixed point input by a truncated continued fraction.
// ---------------------------------------------------------------------------
// Each division runs 76 steps on the shared radix-2 divider (z, each level,
//   the final quotient).
// Zero input: the sequencer goes straight to done, result with invalid set.
// One request at a time; the next request is taken once the
//   result has moved to the output register.
// Reset (rst_n low, synchronous): term_count returns to 8, no result pending.
`default_nettype none

`include "assert_macros.svh"

module continued_fraction_log_unit #(
  parameter int FRAC_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // Configuration write
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [cfl_pkg::K_W-1:0]       cfg_term_count,
  // Request
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  [31:0]                   in_x_value,
  // Result
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic signed [cfl_pkg::OUT_W-1:0] out_ln_value,
  output logic                          out_invalid
);
  import cfl_pkg::*;

  // Most negative code, never produced after saturation
  localparam logic [OUT_W-1:0] LN_MIN = {1'b1, {MAG_W{1'b0}}};

  logic [K_W-1:0]   term_count_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_ln_r;
  logic             out_invalid_r;

  logic             seq_ready;
  logic             accept;
  logic             load;
  cfl_res_t         res;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TERM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      term_count_r <= cfg_term_count;
    end
  end

  // Request handshake
  assign in_stall = !seq_ready;
  assign accept   = in_valid && !in_stall;

  cfl_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (accept),
    .x_i          (in_x_value),
    .term_count_i (term_count_r),
    .res_take_i   (load),
    .ready_o      (seq_ready),
    .res_o        (res),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  cfl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Output register, refilled when empty or being taken
  assign load = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ln_r      <= res.ln;
      out_invalid_r <= res.invalid;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ln_value = out_ln_r;
  assign out_invalid  = out_invalid_r;

  `CFL_ASSERT_NXT(a_busy_after_req, clk, rst_n, accept, in_stall, "request taken, unit idle")
  `CFL_ASSERT_IMP(a_invalid_zero, clk, rst_n, out_valid_r && out_invalid_r, out_ln_r == '0, "ln not zero")
  `CFL_ASSERT_IMP(a_no_min_value, clk, rst_n, out_valid_r, out_ln_r != LN_MIN, "magnitude not saturated")

endmodule

`default_nettype wire

FILE: rtl/cfl_div.sv
// ---------------------------------------------------------------------------
// cfl_div
// Radix-2 restoring divider, one quotient bit per cycle, sticky overflow.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfl_div (
  input  wire               clk,
  input  wire               rst_n,
  input  cfl_pkg::div_req_t req_i,
  output cfl_pkg::div_rsp_t rsp_o
);
  import cfl_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic             ovf_r;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift one dividend bit into the remainder per cycle while busy
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= req_i.dividend;
      dsr_r <= req_i.divisor;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      ovf_r <= ovf_r | quo_r[QUO_W-1];
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.ovf  = ovf_r;
  assign rsp_o.quo  = quo_r;

  `CFL_ASSERT_IMP(a_start_idle, clk, rst_n, req_i.start, !busy_r, "divider started while busy")
  `CFL_ASSERT_NXT(a_done_pulse, clk, rst_n, done_r, !done_r, "divider done longer than a cycle")
  `CFL_ASSERT_IMP(a_done_free, clk, rst_n, done_r, !busy_r, "divider done while still busy")

endmodule

`default_nettype wire

FILE: rtl/cfl_seq.sv
// ---------------------------------------------------------------------------
// cfl_seq
// Sequencer and datapath: forms z, z^2 and the fraction levels bottom up,
// sharing one multiplier and one divider.
// ---------------------------------------------------------------------------
`default_nettype none

module cfl_seq #(
  parameter int FRAC_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start_i,
  input  wire  [31:0]                  x_i,
  input  wire  [cfl_pkg::K_W-1:0]      term_count_i,
  input  wire                          res_take_i,
  output logic                         ready_o,
  output cfl_pkg::cfl_res_t            res_o,
  output cfl_pkg::div_req_t            div_req_o,
  input  cfl_pkg::div_rsp_t            div_rsp_i
);
  import cfl_pkg::*;

  localparam logic [31:0]      ONE  = 32'(1) << FRAC_BITS;
  localparam logic [DSR_W-1:0] UNIT = DSR_W'(1) << Z_BITS;
  localparam logic [QUO_W-1:0] CAP  = QUO_W'((1 << MAG_W) - 1);

  cfl_state_t state_r, state_nxt;

  logic [31:0]       x_r;
  logic              neg_r;
  logic [Z_BITS-1:0] zm_r;
  logic [Z_BITS-1:0] z2_r;
  logic [K_W-1:0]    k_r;
  logic [QUO_W-1:0]  acc_r;
  logic [PROD_W-1:0] prod_r;
  logic [OUT_W-1:0]  ln_r;
  logic              inv_r;

  logic              mul_en;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [31:0]       diff;
  logic [32:0]       xp1;
  logic [K_W-1:0]    km1;
  logic [TOP_W-1:0]  top9;
  logic [DSR_W-1:0]  lvl_top;
  logic [DSR_W-1:0]  lvl_den;
  logic [DSR_W-1:0]  fin_den;
  logic              sat;
  logic [MAG_W-1:0]  mag;
  logic [OUT_W-1:0]  mag_ext;

  // |x - 1| and x + 1
  assign diff = neg_r ? (ONE - x_r) : (x_r - ONE);
  assign xp1  = {1'b0, x_r} + {1'b0, ONE};
  assign km1  = k_r - K_W'(1);

  // Level denominator (2k-1)*2^30 - acc, taken as 1 if not positive
  assign top9    = {k_r, 1'b0} - TOP_W'(1);
  assign lvl_top = {top9, {Z_BITS{1'b0}}};
  assign lvl_den = (acc_r < {1'b0, lvl_top}) ? (lvl_top - acc_r[DSR_W-1:0]) : DSR_W'(1);
  assign fin_den = (acc_r < {1'b0, UNIT}) ? (UNIT - acc_r[DSR_W-1:0]) : DSR_W'(1);

  // Final magnitude saturation and sign
  assign sat     = div_rsp_i.ovf || (div_rsp_i.quo > CAP);
  assign mag     = sat ? CAP[MAG_W-1:0] : div_rsp_i.quo[MAG_W-1:0];
  assign mag_ext = {1'b0, mag};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_i) state_nxt = (x_i == 32'd0) ? ST_DONE : ST_ZDIV;
      end
      ST_ZDIV:   state_nxt = ST_ZWAIT;
      ST_ZWAIT: begin
        if (div_rsp_i.done) state_nxt = ST_ZSQ;
      end
      ST_ZSQ:    state_nxt = ST_ZSQ_WB;
      ST_ZSQ_WB: state_nxt = ST_LEVEL;
      ST_LEVEL:  state_nxt = (k_r > K_W'(1)) ? ST_NUM : ST_FDIV;
      ST_NUM:    state_nxt = ST_ADIV;
      ST_ADIV:   state_nxt = ST_AWAIT;
      ST_AWAIT: begin
        if (div_rsp_i.done) state_nxt = ST_LEVEL;
      end
      ST_FDIV:   state_nxt = ST_FWAIT;
      ST_FWAIT: begin
        if (div_rsp_i.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take_i) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: multiplier operands and divider requests
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_req_o = '0;
    unique case (state_r)
      ST_ZDIV: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DVD_W'({diff, {Z_BITS{1'b0}}});
        div_req_o.divisor  = DSR_W'(xp1);
      end
      ST_ZSQ: begin
        mul_en = 1'b1;
        mul_a  = zm_r;
        mul_b  = zm_r;
      end
      ST_LEVEL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(km1);
        mul_b  = MUL_W'(km1);
      end
      ST_NUM: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(prod_r[KSQ_W-1:0]);
        mul_b  = z2_r;
      end
      ST_ADIV: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = {prod_r[NUM_W-1:0], {Z_BITS{1'b0}}};
        div_req_o.divisor  = lvl_den;
      end
      ST_FDIV: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DVD_W'({zm_r, 1'b0}) << FRAC_BITS;
        div_req_o.divisor  = fin_den;
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        x_r   <= x_i;
        neg_r <= x_i < ONE;
        inv_r <= (x_i == 32'd0);
        ln_r  <= '0;
      end
      ST_ZWAIT: begin
        if (div_rsp_i.done) zm_r <= div_rsp_i.quo[Z_BITS-1:0];
      end
      ST_ZSQ_WB: begin
        z2_r  <= prod_r[PROD_W-1:Z_BITS];
        k_r   <= term_count_i;
        acc_r <= '0;
      end
      ST_AWAIT: begin
        if (div_rsp_i.done) begin
          acc_r <= div_rsp_i.ovf ? {QUO_W{1'b1}} : div_rsp_i.quo;
          k_r   <= km1;
        end
      end
      ST_FWAIT: begin
        if (div_rsp_i.done) ln_r <= neg_r ? (OUT_W'(0) - mag_ext) : mag_ext;
      end
      default: begin
      end
    endcase
  end

  assign ready_o       = (state_r == ST_IDLE);
  assign res_o.valid   = (state_r == ST_DONE);
  assign res_o.invalid = inv_r;
  assign res_o.ln      = ln_r;

endmodule

`default_nettype wire
